// File: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/toae_pkg.sv
package toae_pkg;

   localparam logic [7:0] KIND_RESET     = 8'd254;
   localparam logic [7:0] OPT_EOL        = 8'd0;
   localparam logic [7:0] OPT_NOP        = 8'd1;
   localparam logic [7:0] ADDR_OPT_LEN   = 8'd8;
   localparam logic [3:0] BASE_HDR_WORDS = 4'd5;
   localparam int         BYTES_PER_WORD = 4;
   localparam int         OPT_HDR_BYTES  = 2;
   localparam int         PORT_BYTES     = 2;
   localparam logic [2:0] CAPTURE_BYTES  = 3'(ADDR_OPT_LEN - 8'(OPT_HDR_BYTES));

   localparam logic OP_START  = 1'b0;
   localparam logic OP_OPTION = 1'b1;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_SYN   = 3'd1,
      ST_END_LIST  = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_EXHAUSTED = 3'd4
   } status_type;

   typedef struct packed {
      logic       operation;
      logic       syn_flag;
      logic [3:0] data_offset_words;
      logic [7:0] option_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] client_port;
      logic [31:0] client_addr;
   } result_type;

endpackage

// File: src/tcp_option_address_extractor.sv
// TCP option address extractor. Feed one start transfer per TCP header (SYN
// flag and data offset), then the option area bytes one transfer each. The
// block walks the options and gives at most one result per header: the port
// and IPv4 address of the option whose kind matches the csr kind register
// (reset 254) with length 8, or a status of not SYN, end of list, bad option
// length or area exhausted. Option bytes after a result are ignored until
// the next start. The block takes one transfer every cycle while its input
// is not stalled; an accepted byte passes through the input register and
// then the result register, and the walk state updates as the result
// register loads. Backpressure on the result side stalls the input only when
// the result register is full and is not being taken. Write the kind
// register only while the block is idle.
`include "assert_macros.svh"

module tcp_option_address_extractor
   import toae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic        req_syn_flag,
   input  logic [3:0]  req_data_offset_words,
   input  logic [7:0]  req_option_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_client_port,
   output logic [31:0] rsp_client_addr
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       fire;
   logic       result_valid;
   result_type result;
   result_type rsp_result;

   assign req_item = '{operation:         req_operation,
                       syn_flag:          req_syn_flag,
                       data_offset_words: req_data_offset_words,
                       option_byte:       req_option_byte};

   // An item is processed when it sits in the input register and the result
   // register can take whatever it produces.
   assign fire = item_valid && advance;

   toae_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   toae_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item             (item),
      .result_valid     (result_valid),
      .result           (result)
   );

   toae_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result)
   );

   assign rsp_status      = rsp_result.status;
   assign rsp_client_port = rsp_result.client_port;
   assign rsp_client_addr = rsp_result.client_addr;

   // A stalled input is always caused by a full, stalled result register.
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stall without result backpressure")
   // Only a found option carries a port and an address.
   `ASSERT_IMPLIES(a_zero_fields, clock, reset, rsp_valid && rsp_status != ST_FOUND, rsp_client_port == '0 && rsp_client_addr == '0, "nonzero fields on a failed walk")
   // The status code is always one of the defined codes.
   `ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_valid || rsp_status <= ST_EXHAUSTED, "undefined status code")

endmodule

// File: src/toae_input_stage.sv
module toae_input_stage
   import toae_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     vld_ff, vld_in;
   item_type item_ff;
   logic     accept;

   // The held item can move on only when the result side has room.
   assign req_stall = vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

// File: src/toae_parser.sv
module toae_parser
   import toae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       fire,
   input  item_type   item,
   output logic       result_valid,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_KIND      = 3'd1,
      PH_LEN_MATCH = 3'd2,
      PH_LEN_OTHER = 3'd3,
      PH_SKIP      = 3'd4,
      PH_CAPTURE   = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  area_ff, area_in;
   logic [5:0]  skip_ff, skip_in;
   logic [2:0]  cap_idx_ff, cap_idx_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  kind_ff;

   always_comb begin
      logic [7:0] b;
      logic [3:0] extra_words;
      logic [5:0] area_next;
      logic [2:0] idx_next;
      b           = item.option_byte;
      extra_words = item.data_offset_words - BASE_HDR_WORDS;
      area_next   = area_ff;
      idx_next    = cap_idx_ff;

      phase_in     = phase_ff;
      area_in      = area_ff;
      skip_in      = skip_ff;
      cap_idx_in   = cap_idx_ff;
      port_in      = port_ff;
      addr_in      = addr_ff;
      result_valid = 1'b0;
      result       = '{status: ST_FOUND, client_port: '0, client_addr: '0};

      if (item.operation == OP_START) begin
         skip_in    = '0;
         cap_idx_in = '0;
         port_in    = '0;
         addr_in    = '0;
         area_in    = '0;
         if (!item.syn_flag) begin
            result_valid  = 1'b1;
            result.status = ST_NOT_SYN;
            phase_in      = PH_IDLE;
         end else if (item.data_offset_words <= BASE_HDR_WORDS) begin
            result_valid  = 1'b1;
            result.status = ST_EXHAUSTED;
            phase_in      = PH_IDLE;
         end else begin
            area_in  = 6'(extra_words * BYTES_PER_WORD);
            phase_in = PH_KIND;
         end
      end else begin
         unique case (phase_ff)
            PH_KIND: begin
               if (b == OPT_EOL) begin
                  result_valid  = 1'b1;
                  result.status = ST_END_LIST;
                  phase_in      = PH_IDLE;
               end else if (b == OPT_NOP) begin
                  area_next = area_ff - 6'd1;
                  area_in   = area_next;
                  if (area_next == '0) begin
                     result_valid  = 1'b1;
                     result.status = ST_EXHAUSTED;
                     phase_in      = PH_IDLE;
                  end
               end else if (b == kind_ff) begin
                  phase_in = PH_LEN_MATCH;
               end else begin
                  phase_in = PH_LEN_OTHER;
               end
            end
            PH_LEN_MATCH, PH_LEN_OTHER: begin
               if (b < 8'(OPT_HDR_BYTES) || b > {2'b00, area_ff}) begin
                  result_valid  = 1'b1;
                  result.status = ST_BAD_LEN;
                  phase_in      = PH_IDLE;
               end else if (phase_ff == PH_LEN_MATCH && b == ADDR_OPT_LEN) begin
                  cap_idx_in = '0;
                  port_in    = '0;
                  addr_in    = '0;
                  phase_in   = PH_CAPTURE;
               end else begin
                  // The length fits in the area here, so six bits carry it.
                  area_next = area_ff - b[5:0];
                  area_in   = area_next;
                  skip_in   = b[5:0] - 6'(OPT_HDR_BYTES);
                  if (skip_in != '0) begin
                     phase_in = PH_SKIP;
                  end else if (area_next == '0) begin
                     result_valid  = 1'b1;
                     result.status = ST_EXHAUSTED;
                     phase_in      = PH_IDLE;
                  end else begin
                     phase_in = PH_KIND;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 6'd1;
               if (skip_in == '0) begin
                  if (area_ff == '0) begin
                     result_valid  = 1'b1;
                     result.status = ST_EXHAUSTED;
                     phase_in      = PH_IDLE;
                  end else begin
                     phase_in = PH_KIND;
                  end
               end
            end
            PH_CAPTURE: begin
               if (cap_idx_ff < 3'(PORT_BYTES)) begin
                  port_in = {port_ff[7:0], b};
               end else begin
                  addr_in = {addr_ff[23:0], b};
               end
               idx_next   = cap_idx_ff + 3'd1;
               cap_idx_in = idx_next;
               if (idx_next >= CAPTURE_BYTES) begin
                  cap_idx_in         = '0;
                  result_valid       = 1'b1;
                  result.status      = ST_FOUND;
                  result.client_port = port_in;
                  result.client_addr = addr_in;
                  phase_in           = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         area_ff    <= '0;
         skip_ff    <= '0;
         cap_idx_ff <= '0;
         port_ff    <= '0;
         addr_ff    <= '0;
         kind_ff    <= KIND_RESET;
      end else begin
         if (fire) begin
            phase_ff   <= phase_in;
            area_ff    <= area_in;
            skip_ff    <= skip_in;
            cap_idx_ff <= cap_idx_in;
            port_ff    <= port_in;
            addr_ff    <= addr_in;
         end
         if (csr_write_enable) begin
            kind_ff <= csr_write_data;
         end
      end
   end

endmodule

// File: src/toae_output_stage.sv
module toae_output_stage
   import toae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       result_valid,
   input  result_type result,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic       vld_ff, vld_in;
   result_type result_ff;
   logic       load;

   // Room exists when the register is empty or its transfer completes now.
   assign advance = !vld_ff || !rsp_stall;
   assign load    = fire && result_valid;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = vld_ff;
   assign rsp_result = result_ff;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

// Checks the TCP option address extractor against a cycle-free model of the
// option walk. Items go in through a sender task, one transfer at a time,
// and every accepted transfer is fed to the model, which may queue one
// expected report. A single scoreboard process, run at the rising edge,
// compares each result transfer with the oldest queued report and feeds the
// model with each accepted input transfer.
module testbench;
   import toae_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 60;

   // Option kinds used by the directed tests. None of them is EOL or NOP.
   localparam logic [7:0] KIND_OTHER = 8'd9;
   localparam logic [7:0] KIND_LATE  = 8'd7;
   localparam logic [7:0] KIND_TOP   = 8'd255;

   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_KIND,
      WALK_LEN_MATCH,
      WALK_LEN_OTHER,
      WALK_SKIP,
      WALK_CAPTURE
   } walk_phase_type;

   typedef logic [7:0] byte_list_type[$];

   // Every input of the block starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_START;
   logic        req_syn_flag = 1'b0;
   logic [3:0]  req_data_offset_words = 4'd0;
   logic [7:0]  req_option_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_client_port;
   logic [31:0] rsp_client_addr;

   // Model of the walk: the kind register and the parser state.
   logic [7:0]     addr_kind = KIND_RESET;
   walk_phase_type walk_phase = WALK_IDLE;
   logic [5:0]     area_left = '0;
   logic [5:0]     skip_left = '0;
   logic [2:0]     cap_index = '0;
   logic [15:0]    cap_port = '0;
   logic [31:0]    cap_addr = '0;

   result_type pending_reports[$];

   int          failure_count = 0;
   int          items_sent = 0;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b1;

   // The pressure test asks the receiver for a long hold-off through
   // hold_request; the receiver counts it down on its own.
   int hold_request = 0;
   int hold_count = 0;
   int stall_burst = 0;
   int gap_length;

   tcp_option_address_extractor dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_syn_flag          (req_syn_flag),
      .req_data_offset_words (req_data_offset_words),
      .req_option_byte       (req_option_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_client_port       (rsp_client_port),
      .rsp_client_addr       (rsp_client_addr)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   // A hang in either handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void note_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // Advances the walk model by one accepted transfer. Returns 1 when the
   // transfer closes the header, with the report in res. Any report puts the
   // walk back to idle, and option bytes seen while idle are dropped.
   function automatic bit predict_walk(input item_type it, output result_type res);
      bit done;
      bit option_over;
      done = 1'b0;
      option_over = 1'b0;
      res.status = ST_FOUND;
      res.client_port = '0;
      res.client_addr = '0;
      if (it.operation == OP_START) begin
         // A start always opens a fresh header, even in the middle of a walk.
         skip_left = '0;
         cap_index = '0;
         cap_port = '0;
         cap_addr = '0;
         area_left = '0;
         if (!it.syn_flag) begin
            res.status = ST_NOT_SYN;
            done = 1'b1;
         end else if (it.data_offset_words <= BASE_HDR_WORDS) begin
            res.status = ST_EXHAUSTED;
            done = 1'b1;
         end else begin
            area_left = 6'((it.data_offset_words - BASE_HDR_WORDS) * BYTES_PER_WORD);
            walk_phase = WALK_KIND;
         end
      end else begin
         case (walk_phase)
            WALK_KIND: begin
               // EOL and NOP win over the kind register.
               if (it.option_byte == OPT_EOL) begin
                  res.status = ST_END_LIST;
                  done = 1'b1;
               end else if (it.option_byte == OPT_NOP) begin
                  area_left = area_left - 6'd1;
                  option_over = 1'b1;
               end else if (it.option_byte == addr_kind) begin
                  walk_phase = WALK_LEN_MATCH;
               end else begin
                  walk_phase = WALK_LEN_OTHER;
               end
            end
            WALK_LEN_MATCH, WALK_LEN_OTHER: begin
               // The length covers the kind and length bytes themselves.
               if (it.option_byte < OPT_HDR_BYTES || it.option_byte > area_left) begin
                  res.status = ST_BAD_LEN;
                  done = 1'b1;
               end else if (walk_phase == WALK_LEN_MATCH && it.option_byte == ADDR_OPT_LEN) begin
                  cap_index = '0;
                  cap_port = '0;
                  cap_addr = '0;
                  walk_phase = WALK_CAPTURE;
               end else begin
                  area_left = area_left - it.option_byte[5:0];
                  skip_left = 6'(it.option_byte - OPT_HDR_BYTES);
                  if (skip_left != 0)
                     walk_phase = WALK_SKIP;
                  else
                     option_over = 1'b1;
               end
            end
            WALK_SKIP: begin
               skip_left = skip_left - 6'd1;
               if (skip_left == 0)
                  option_over = 1'b1;
            end
            WALK_CAPTURE: begin
               // Port bytes first, then the address, both in wire order.
               if (cap_index < PORT_BYTES)
                  cap_port = {cap_port[7:0], it.option_byte};
               else
                  cap_addr = {cap_addr[23:0], it.option_byte};
               cap_index = cap_index + 3'd1;
               if (cap_index >= CAPTURE_BYTES) begin
                  cap_index = '0;
                  res.client_port = cap_port;
                  res.client_addr = cap_addr;
                  done = 1'b1;
               end
            end
            default: walk_phase = WALK_IDLE;
         endcase
      end
      // After a whole option or a NOP the area may be used up exactly.
      if (option_over) begin
         if (area_left == 0) begin
            res.status = ST_EXHAUSTED;
            done = 1'b1;
         end else begin
            walk_phase = WALK_KIND;
         end
      end
      if (done)
         walk_phase = WALK_IDLE;
      return done;
   endfunction

   // Scoreboard. Results are checked before the input side is modeled, but
   // a result can never belong to a transfer taken at the same edge, since
   // the transfer must first pass the input register and the result register.
   always @(posedge clock) begin : scoreboard
      result_type want;
      result_type predicted;
      item_type   taken;
      if (reset) begin
         addr_kind = KIND_RESET;
         walk_phase = WALK_IDLE;
         area_left = '0;
         skip_left = '0;
         cap_index = '0;
         cap_port = '0;
         cap_addr = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               note_failure($sformatf("result with none expected: status %0d port %h addr %h",
                                      rsp_status, rsp_client_port, rsp_client_addr));
            end else begin
               want = pending_reports.pop_front();
               if (rsp_status !== want.status || rsp_client_port !== want.client_port
                   || rsp_client_addr !== want.client_addr)
                  note_failure($sformatf({"mismatch: expected status %0d port %h addr %h,",
                                          " got status %0d port %h addr %h"},
                                         want.status, want.client_port, want.client_addr,
                                         rsp_status, rsp_client_port, rsp_client_addr));
            end
         end
         if (csr_write_enable)
            addr_kind = csr_write_data;
         if (req_valid && !req_stall) begin
            taken = '{req_operation, req_syn_flag, req_data_offset_words, req_option_byte};
            if (predict_walk(taken, predicted))
               pending_reports.push_back(predicted);
         end
      end
   end

   // Receiver. It stalls in random bursts while idling is on, and holds off
   // for a whole stretch when the pressure test asks.
   always @(negedge clock) begin : receiver
      if (hold_request != 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count != 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else if (stall_burst != 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_burst = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Fields that the operation does not read still get random values, so
   // every input bit toggles.
   function automatic item_type start_item(input logic syn, input logic [3:0] doff);
      return '{OP_START, syn, doff, 8'($urandom)};
   endfunction

   function automatic item_type option_item(input logic [7:0] value);
      return '{OP_OPTION, 1'($urandom), 4'($urandom), value};
   endfunction

   // Option data leans toward all-zero and all-one bytes.
   function automatic logic [7:0] random_data_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Sends one transfer: an optional idle gap, then the payload at the
   // falling edge, held until a rising edge sees no stall. Valid stays high
   // on return so that back-to-back transfers need no extra edge.
   task automatic send_item(input item_type it);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap_length = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap_length - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= it.operation;
      req_syn_flag <= it.syn_flag;
      req_data_offset_words <= it.data_offset_words;
      req_option_byte <= it.option_byte;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_header(input logic syn, input logic [3:0] doff,
                              input byte_list_type area);
      send_item(start_item(syn, doff));
      foreach (area[i])
         send_item(option_item(area[i]));
   endtask

   // Drops valid, waits for every queued report, then lets the pipeline
   // settle, since an option byte that gives no report may still be inside.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The kind register is written only with the block idle: a non-SYN start
   // closes whatever walk is open, and its report drains first.
   task automatic write_kind(input logic [7:0] kind);
      send_item(start_item(1'b0, 4'($urandom)));
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= kind;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Start transfers that report at once, and a stray option byte while idle.
   task automatic test_start_items();
      send_item(option_item(8'hFF));
      send_item(start_item(1'b0, 4'd15));
      send_item(start_item(1'b1, 4'd0));
      send_item(start_item(1'b1, BASE_HDR_WORDS));
   endtask

   // The reset kind with all-ones port and address, then a byte after the
   // report that must be ignored.
   task automatic test_address_found();
      send_header(1'b1, 4'd7, '{KIND_RESET, ADDR_OPT_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                8'hFF, 8'hFF});
      send_item(option_item(OPT_EOL));
   endtask

   task automatic test_option_walk();
      // A walk cut short by the next start gives no report of its own.
      send_header(1'b1, 4'd6, '{KIND_OTHER});
      // The matching kind with a length other than 8 is skipped, then a
      // length of zero is rejected.
      send_header(1'b1, 4'd15, '{KIND_RESET, 8'd4, 8'h5A, 8'hA5, KIND_OTHER, 8'd0});
      send_header(1'b1, 4'd6, '{OPT_EOL});
      // Two NOPs and a two-byte option fill the area exactly.
      send_header(1'b1, 4'd6, '{OPT_NOP, OPT_NOP, KIND_OTHER, 8'd2});
      // A kind in the last area byte: its length can never fit.
      send_header(1'b1, 4'd6, '{KIND_OTHER, 8'd2, OPT_NOP, KIND_LATE, 8'd2});
   endtask

   // Extreme register values. A kind of EOL or NOP never matches, since
   // those two codes are decided first.
   task automatic test_kind_register();
      write_kind(OPT_EOL);
      send_header(1'b1, 4'd6, '{OPT_EOL});
      write_kind(OPT_NOP);
      send_header(1'b1, 4'd6, '{OPT_NOP, OPT_NOP, OPT_NOP, OPT_NOP});
      write_kind(KIND_TOP);
      send_header(1'b1, 4'd7, '{KIND_TOP, ADDR_OPT_LEN, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00, 8'h00});
   endtask

   // The receiver holds off while every start reports, so the block fills
   // up and has to stall its input.
   task automatic test_result_backpressure();
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      repeat (16) send_item(start_item(1'b0, 4'($urandom)));
      wait_drained();
   endtask

   // One header of random but mostly well-formed options. Some headers are
   // cut short, and some carry trailing bytes past their report.
   task automatic send_random_header();
      byte_list_type area;
      logic [7:0]    kind;
      logic          syn;
      logic [3:0]    doff;
      int            room;
      int            left;
      int            len;
      int            pick;
      syn = ($urandom_range(0, 9) != 0);
      doff = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(6, 9));
      room = (doff > BASE_HDR_WORDS) ? (doff - BASE_HDR_WORDS) * BYTES_PER_WORD : 0;
      while (area.size() < room) begin
         left = room - area.size();
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            area.push_back(OPT_EOL);
         end else if (pick < 5) begin
            area.push_back(OPT_NOP);
         end else if (pick < 11 && left >= ADDR_OPT_LEN) begin
            area.push_back(addr_kind);
            area.push_back(ADDR_OPT_LEN);
            repeat (ADDR_OPT_LEN - OPT_HDR_BYTES) area.push_back(random_data_byte());
         end else if (pick == 11) begin
            // Arbitrary kind and length, often a broken option.
            area.push_back(8'($urandom));
            area.push_back(8'($urandom));
         end else begin
            do kind = 8'($urandom_range(2, 255)); while (kind == addr_kind);
            len = $urandom_range(OPT_HDR_BYTES, (left > 12) ? 12 : ((left < 2) ? 2 : left));
            area.push_back(kind);
            area.push_back(8'(len));
            repeat (len - OPT_HDR_BYTES) area.push_back(random_data_byte());
         end
      end
      if (area.size() != 0 && $urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, area.size())) void'(area.pop_back());
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) area.push_back(8'($urandom));
      send_header(syn, doff, area);
   endtask

   task automatic test_random_walks(input int target, input bit with_idling);
      idling_on = with_idling;
      while (items_sent < target) begin
         if ($urandom_range(0, 14) == 0)
            write_kind(8'($urandom_range(2, 255)));
         send_random_header();
      end
   endtask

   initial begin : main
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_start_items();
      test_address_found();
      test_option_walk();
      test_kind_register();
      test_result_backpressure();
      test_random_walks(330, 1'b1);
      // The last part runs with both sides at full rate.
      test_random_walks(400, 1'b0);

      wait_drained();
      if (pending_reports.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", pending_reports.size()));
      if (failure_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/toae_pkg.sv
src/toae_input_stage.sv
src/toae_parser.sv
src/toae_output_stage.sv
src/tcp_option_address_extractor.sv
bench/testbench.sv
